[src/p2r_pkg.sv]
// ----------------------------------------------------------------------------
// p2r_pkg
// Types, format codes and YUV coefficients for the pixel format converter.
// ----------------------------------------------------------------------------
package p2r_pkg;

    typedef enum logic [2:0] {
        FMT_RGB24  = 3'd0,
        FMT_BGR24  = 3'd1,
        FMT_RGB32  = 3'd2,
        FMT_BGR32  = 3'd3,
        FMT_RGB565 = 3'd4,
        FMT_RGB555 = 3'd5,
        FMT_YUYV   = 3'd6
    } t_fmt;

    localparam int          REG_FMT     = 0;
    localparam int          FIFO_DEPTH  = 2;
    localparam int          FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int          PROD_W      = 27;
    localparam int          SUM_W       = 28;

    // Q16 coefficients, combined factors rounded to nearest
    localparam logic signed [18:0] K_Y  = 19'sd76309;
    localparam logic signed [18:0] K_R  = 19'sd104187;
    localparam logic signed [18:0] K_GU = 19'sd25564;
    localparam logic signed [18:0] K_GV = 19'sd53060;
    localparam logic signed [18:0] K_B  = 19'sd131683;

    typedef struct packed {
        logic [31:0] source_word;
        logic        line_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_run;
        logic       line_done;
    } t_pixel;

    // classified word: byte formats carry r,g,b in a,b,c; YUYV carries Y0,U,Y1,V
    typedef struct packed {
        logic       yuv;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic       line_end;
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

    typedef struct packed {
        logic vld;
        logic full;
        t_op  head;
    } t_q_stat;

endpackage

[src/p2r_front.sv]
// ----------------------------------------------------------------------------
// p2r_front
// Accepts source words and classifies them by pixel format into queue ops.
// ----------------------------------------------------------------------------
module p2r_front import p2r_pkg::*; (
    input  logic     i_take,
    input  t_in_word i_word,
    input  t_fmt     i_fmt,
    output t_push    o_push
);

    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] h;

    assign b0 = i_word.source_word[7:0];
    assign b1 = i_word.source_word[15:8];
    assign b2 = i_word.source_word[23:16];
    assign b3 = i_word.source_word[31:24];
    assign h  = i_word.source_word[15:0];

    always_comb begin
        o_push.push        = i_take;
        o_push.op.yuv      = 1'b0;
        o_push.op.a        = b0;
        o_push.op.b        = b1;
        o_push.op.c        = b2;
        o_push.op.d        = b3;
        o_push.op.line_end = i_word.line_end;
        case (i_fmt)
            FMT_RGB24, FMT_RGB32: begin
            end
            FMT_BGR24, FMT_BGR32: begin
                o_push.op.a = b2;
                o_push.op.c = b0;
            end
            FMT_RGB565: begin
                o_push.op.a = {h[15:11], 3'b000};
                o_push.op.b = {h[10:5], 2'b00};
                o_push.op.c = {h[4:0], 3'b000};
            end
            FMT_RGB555: begin
                o_push.op.a = {h[14:10], 3'b000};
                o_push.op.b = {h[9:5], 3'b000};
                o_push.op.c = {h[4:0], 3'b000};
            end
            FMT_YUYV: begin
                o_push.op.yuv = 1'b1;
            end
            default: begin
                o_push.push = 1'b0;
            end
        endcase
    end

endmodule

[src/p2r_fifo.sv]
// ----------------------------------------------------------------------------
// p2r_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module p2r_fifo import p2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_q_stat o_stat
);

    t_op                  r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_cnt, n_cnt;
    logic                 do_push, do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign do_push = i_push.push && (r_cnt != (FIFO_AW+1)'(FIFO_DEPTH));

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.op;
        end
    end

    assign o_stat.vld  = (r_cnt != '0);
    assign o_stat.full = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.head = r_mem[r_rd];

endmodule

[src/p2r_back.sv]
// ----------------------------------------------------------------------------
// p2r_back
// Emits pixels from queued ops: products stage, then sum/clamp output stage.
// ----------------------------------------------------------------------------
module p2r_back import p2r_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_stat,
    output logic    o_pop,
    output logic    o_valid,
    output t_pixel  o_pixel
);

    logic                     r_sub;
    logic                     last;
    logic [7:0]               y;
    logic signed [9:0]        dy;
    logic signed [8:0]        du, dv;

    logic                     r_s1_vld, r_s1_yuv, r_s1_last, r_s1_done;
    logic [23:0]              r_s1_rgb;
    logic signed [PROD_W-1:0] r_ly, r_pr, r_pgu, r_pgv, r_pb;

    logic signed [SUM_W-1:0]  sum_r, sum_g, sum_b;
    logic                     r_out_vld;
    t_pixel                   r_out, n_out;

    function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] acc);
        logic [7:0] v;
        if (acc[SUM_W-1]) begin
            v = 8'd0;
        end else if (acc[SUM_W-2:24] != '0) begin
            v = 8'hff;
        end else begin
            v = acc[23:16];
        end
        return v;
    endfunction

    assign last  = !i_stat.head.yuv || r_sub;
    assign o_pop = i_stat.vld && last;
    assign y     = r_sub ? i_stat.head.c : i_stat.head.a;
    assign dy    = $signed({2'b00, y}) - 10'sd16;
    assign du    = $signed({1'b0, i_stat.head.b}) - 9'sd128;
    assign dv    = $signed({1'b0, i_stat.head.d}) - 9'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub     <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_stat.vld && i_stat.head.yuv) begin
                r_sub <= !r_sub;
            end
            r_s1_vld  <= i_stat.vld;
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_yuv  <= i_stat.head.yuv;
        r_s1_last <= last;
        r_s1_done <= last && i_stat.head.line_end;
        r_s1_rgb  <= {i_stat.head.a, i_stat.head.b, i_stat.head.c};
        r_ly      <= PROD_W'(K_Y)  * PROD_W'(dy);
        r_pr      <= PROD_W'(K_R)  * PROD_W'(dv);
        r_pgu     <= PROD_W'(K_GU) * PROD_W'(du);
        r_pgv     <= PROD_W'(K_GV) * PROD_W'(dv);
        r_pb      <= PROD_W'(K_B)  * PROD_W'(du);
        r_out     <= n_out;
    end

    assign sum_r = SUM_W'(r_ly) + SUM_W'(r_pr);
    assign sum_g = SUM_W'(r_ly) - SUM_W'(r_pgu) - SUM_W'(r_pgv);
    assign sum_b = SUM_W'(r_ly) + SUM_W'(r_pb);

    always_comb begin
        n_out.last_of_run = r_s1_last;
        n_out.line_done   = r_s1_done;
        if (r_s1_yuv) begin
            n_out.red   = clamp_q16(sum_r);
            n_out.green = clamp_q16(sum_g);
            n_out.blue  = clamp_q16(sum_b);
        end else begin
            n_out.red   = r_s1_rgb[23:16];
            n_out.green = r_s1_rgb[15:8];
            n_out.blue  = r_s1_rgb[7:0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

endmodule

[src/pixel_format_to_rgb24_top.sv]
// ----------------------------------------------------------------------------
// pixel_format_to_rgb24_top
// Converts captured source words to RGB24 pixels under a format register.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   input    | start / busy          | i_word  (t_in_word)
//   result   | o_valid strobe        | o_pixel (t_pixel)
//   config   | APB, pready tied high | pwdata[2:0] -> pixel_format
//
// Path from accepted word to first pixel: queue, products, sum/clamp output.
// One word per cycle for byte and 16-bit formats; YUYV words give two pixels,
// one per cycle, set by the back end's single multiplier set.
// busy rises when the 2-entry queue is full. Results cannot be stalled.
// Synchronous active-low reset clears control state and sets format RGB24.
// ----------------------------------------------------------------------------
module pixel_format_to_rgb24_top import p2r_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_word,
    output logic        o_valid,
    output t_pixel      o_pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_fmt    r_fmt;
    t_push   push;
    t_q_stat stat;
    logic    pop;
    logic    take;
    logic    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(REG_FMT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB24;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_fmt <= t_fmt'(pwdata[2:0]);
        end
    end

    assign prdata = reg_sel ? {29'd0, r_fmt} : 32'd0;
    assign busy   = stat.full;
    assign take   = start && !busy;

    p2r_front u_front (
        .i_take (take),
        .i_word (i_word),
        .i_fmt  (r_fmt),
        .o_push (push)
    );

    p2r_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (stat)
    );

    p2r_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_pixel (o_pixel)
    );

endmodule

[src/p2r_checker.sv]
// ----------------------------------------------------------------------------
// p2r_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module p2r_checker import p2r_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input t_pixel      o_pixel,
    input logic [31:0] prdata
);

    // first YUYV pixel is always followed at once by the second
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel.last_of_run |=> o_valid && o_pixel.last_of_run)
        else $error("second pixel of word missing");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel.last_of_run |-> !o_pixel.line_done)
        else $error("line_done on non-final pixel");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("outputs active after reset");

    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[31:3] == '0)
        else $error("read data upper bits set");

endmodule

bind pixel_format_to_rgb24_top p2r_checker u_p2r_checker (.*);
